>>> src/circular_fifo_queue_assert.svh
// Assertion macros for the circular FIFO queue.
// Used by the top level; it needs i_clk and i_rst_n in scope.
`ifndef CIRCULAR_FIFO_QUEUE_ASSERT_SVH
`define CIRCULAR_FIFO_QUEUE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define CFQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("circular_fifo_queue: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define CFQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("circular_fifo_queue: next-cycle check failed");

`endif

>>> src/cfq_pkg.sv
// Shared types, constants and helper functions of the circular FIFO queue.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package cfq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CFG_W      = 5;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [1:0]            t_func;
    typedef logic [1:0]            t_status;
    typedef logic [CFG_W-1:0]      t_cfg;

    localparam t_func FUNC_APPEND      = 2'd0;
    localparam t_func FUNC_REMOVE      = 2'd1;
    localparam t_func FUNC_PEEK_OLDEST = 2'd2;
    localparam t_func FUNC_PEEK_NEWEST = 2'd3;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic exec;
        logic load_out;
    } t_cmd;

    function automatic t_cnt clamp_cap(t_cfg v);
        t_cnt res;
        if (v == '0) begin
            res = t_cnt'(1);
        end else if (int'(v) > DEPTH) begin
            res = t_cnt'(DEPTH);
        end else begin
            res = t_cnt'(v);
        end
        return res;
    endfunction

    function automatic t_idx wrap_next(t_idx idx, t_cnt cap);
        int   nxt;
        t_idx res;
        nxt = int'(idx) + 1;
        if (nxt >= int'(cap) || nxt >= DEPTH) begin
            res = '0;
        end else begin
            res = t_idx'(nxt);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/circular_fifo_queue.sv
// Circular FIFO queue of sixteen 32-bit slots with append, remove and peek
// operations. When a word is accepted, the slot memory is read into a
// register; the result is then loaded into the output register once that
// register is free or its result is taken. The output register frees
// the input side, so a new word is accepted while a result still waits to be
// taken. A capacity write empties the queue and takes effect at once.
// Top level; depends on cfq_pkg, cfq_ctrl, cfq_dp and circular_fifo_queue_assert.svh.
`default_nettype none

`include "circular_fifo_queue_assert.svh"

module circular_fifo_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire cfq_pkg::t_func    i_func,
    input  wire cfq_pkg::t_data    i_data_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output cfq_pkg::t_data         o_data_out,
    output cfq_pkg::t_status       o_status,
    output cfq_pkg::t_cnt          o_occupancy,
    output logic                   o_is_empty,
    output logic                   o_is_full,
    input  wire logic              i_cfg_we,
    input  wire cfq_pkg::t_cfg     i_cfg_data
);

    cfq_pkg::t_cmd cmd;

    cfq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    cfq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_func      (i_func),
        .i_data_in   (i_data_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_occupancy (o_occupancy),
        .o_is_empty  (o_is_empty),
        .o_is_full   (o_is_full)
    );

    `CFQ_ASSERT_SAME(a_empty_flag, o_out_valid, o_is_empty == (o_occupancy == '0))
    `CFQ_ASSERT_SAME(a_full_status, o_out_valid && (o_status == cfq_pkg::STATUS_FULL), o_is_full)
    `CFQ_ASSERT_SAME(a_error_zero, o_out_valid && (o_status != cfq_pkg::STATUS_OK), o_data_out == '0)
    `CFQ_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

endmodule

`default_nettype wire

>>> src/cfq_ctrl.sv
// Controller of the circular FIFO queue: sequences one word from acceptance to
// the output register. Depends on cfq_pkg.
`default_nettype none

module cfq_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output cfq_pkg::t_cmd    o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOAD = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    always_comb begin
        out_free       = !r_out_valid || i_out_ready;
        o_cmd.exec     = 1'b0;
        o_cmd.load_out = 1'b0;
        n_state        = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.load_out || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> src/cfq_dp.sv
// Datapath of the circular FIFO queue: slot memory, head and tail indices,
// count, capacity and the result registers. Depends on cfq_pkg.
`default_nettype none

module cfq_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cfq_pkg::t_cmd     i_cmd,
    input  wire cfq_pkg::t_func    i_func,
    input  wire cfq_pkg::t_data    i_data_in,
    input  wire logic              i_cfg_we,
    input  wire cfq_pkg::t_cfg     i_cfg_data,
    output cfq_pkg::t_data         o_data_out,
    output cfq_pkg::t_status       o_status,
    output cfq_pkg::t_cnt          o_occupancy,
    output logic                   o_is_empty,
    output logic                   o_is_full
);

    cfq_pkg::t_data   r_mem [cfq_pkg::DEPTH];
    cfq_pkg::t_data   r_rd_data;
    cfq_pkg::t_idx    r_head, n_head;
    cfq_pkg::t_idx    r_tail, n_tail;
    cfq_pkg::t_cnt    r_count, n_count;
    cfq_pkg::t_cnt    r_cap;
    cfq_pkg::t_cnt    cfg_cap;
    cfq_pkg::t_status n_status, r_res_status;
    logic             n_use_rd, r_res_use_rd;
    cfq_pkg::t_cnt    r_res_count;
    cfq_pkg::t_idx    rd_addr;
    cfq_pkg::t_idx    wr_addr;
    logic             do_write;

    cfq_pkg::t_data   r_data_out;
    cfq_pkg::t_status r_status;
    cfq_pkg::t_cnt    r_occupancy;
    logic             r_is_empty;
    logic             r_is_full;

    always_comb begin
        cfg_cap  = cfq_pkg::clamp_cap(i_cfg_data);
        rd_addr  = (i_func == cfq_pkg::FUNC_PEEK_NEWEST) ? r_tail : r_head;
        wr_addr  = cfq_pkg::wrap_next(r_tail, r_cap);
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = cfq_pkg::STATUS_OK;
        n_use_rd = 1'b0;
        do_write = 1'b0;
        if (i_func == cfq_pkg::FUNC_APPEND) begin
            if (r_count >= r_cap) begin
                n_status = cfq_pkg::STATUS_FULL;
            end else begin
                do_write = 1'b1;
                n_tail   = wr_addr;
                n_count  = r_count + 1'b1;
            end
        end else if (r_count == '0) begin
            n_status = cfq_pkg::STATUS_EMPTY;
        end else begin
            n_use_rd = 1'b1;
            if (i_func == cfq_pkg::FUNC_REMOVE) begin
                n_head  = cfq_pkg::wrap_next(r_head, r_cap);
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[rd_addr];
            if (do_write) begin
                r_mem[wr_addr] <= i_data_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= cfq_pkg::t_cnt'(cfq_pkg::DEPTH);
            r_head  <= '0;
            r_tail  <= cfq_pkg::t_idx'(cfq_pkg::DEPTH - 1);
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_cap   <= cfg_cap;
            r_head  <= '0;
            r_tail  <= cfq_pkg::t_idx'(cfg_cap - 1'b1);
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_status <= n_status;
            r_res_use_rd <= n_use_rd;
            r_res_count  <= n_count;
        end
        if (i_cmd.load_out) begin
            r_data_out  <= r_res_use_rd ? r_rd_data : '0;
            r_status    <= r_res_status;
            r_occupancy <= r_res_count;
            r_is_empty  <= (r_res_count == '0);
            r_is_full   <= (r_res_count == r_cap);
        end
    end

    assign o_data_out  = r_data_out;
    assign o_status    = r_status;
    assign o_occupancy = r_occupancy;
    assign o_is_empty  = r_is_empty;
    assign o_is_full   = r_is_full;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for circular_fifo_queue: directed table, then random phases
// under random valid/ready gaps, each result checked against a predictor or table row.
// Depends on cfq_pkg and the circular_fifo_queue RTL.
`default_nettype none

module tb_top;
    import cfq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 4;
    localparam int PHASES      = 10;

    typedef struct packed {
        t_data   data;
        t_status status;
        t_cnt    occ;
        logic    empty;
        logic    full;
    } t_result;

    typedef struct packed {
        logic    is_cfg;
        t_cfg    cfg;
        t_func   op;
        t_data   data;
        logic    typed;
        t_result want;
    } t_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_in_valid;
    logic    o_in_ready;
    t_func   i_func;
    t_data   i_data_in;
    logic    o_out_valid;
    logic    i_out_ready;
    t_data   o_data_out;
    t_status o_status;
    t_cnt    o_occupancy;
    logic    o_is_empty;
    logic    o_is_full;
    logic    i_cfg_we;
    t_cfg    i_cfg_data;

    // Predictor state of the queue.
    t_data q_slots [DEPTH];
    t_idx  q_head;
    t_idx  q_tail;
    t_cnt  q_count;
    t_cnt  q_cap;

    t_result expected_results [$];
    logic    cur_typed;
    t_result cur_want;
    logic    tx_burst;
    logic    rx_burst;
    int      rx_gap;
    int      errors;
    int      cycles;
    int      words_in;
    int      results_checked;
    int      full_seen;
    int      empty_seen;
    int      cap_writes;

    t_row directed_plan [0:29] = '{
        '{1'b0, 5'd0, FUNC_REMOVE,      32'h0,        1'b1,
          '{32'h0, STATUS_EMPTY, 5'd0, 1'b1, 1'b0}},
        '{1'b0, 5'd0, FUNC_PEEK_OLDEST, 32'hDEADBEEF, 1'b1,
          '{32'h0, STATUS_EMPTY, 5'd0, 1'b1, 1'b0}},
        '{1'b0, 5'd0, FUNC_PEEK_NEWEST, 32'h0,        1'b1,
          '{32'h0, STATUS_EMPTY, 5'd0, 1'b1, 1'b0}},
        '{1'b0, 5'd0, FUNC_APPEND,      32'hFFFFFFFF, 1'b1,
          '{32'h0, STATUS_OK, 5'd1, 1'b0, 1'b0}},
        '{1'b0, 5'd0, FUNC_APPEND,      32'h0,        1'b1,
          '{32'h0, STATUS_OK, 5'd2, 1'b0, 1'b0}},
        '{1'b0, 5'd0, FUNC_PEEK_OLDEST, 32'h0,        1'b1,
          '{32'hFFFFFFFF, STATUS_OK, 5'd2, 1'b0, 1'b0}},
        '{1'b0, 5'd0, FUNC_PEEK_NEWEST, 32'h0,        1'b1,
          '{32'h0, STATUS_OK, 5'd2, 1'b0, 1'b0}},
        '{1'b0, 5'd0, FUNC_REMOVE,      32'h0,        1'b1,
          '{32'hFFFFFFFF, STATUS_OK, 5'd1, 1'b0, 1'b0}},
        '{1'b1, 5'd0,  FUNC_APPEND,     32'h0,        1'b0, '0},
        '{1'b0, 5'd0, FUNC_APPEND,      32'hA5A5A5A5, 1'b1,
          '{32'h0, STATUS_OK, 5'd1, 1'b0, 1'b1}},
        '{1'b0, 5'd0, FUNC_APPEND,      32'h5A5A5A5A, 1'b1,
          '{32'h0, STATUS_FULL, 5'd1, 1'b0, 1'b1}},
        '{1'b0, 5'd0, FUNC_PEEK_NEWEST, 32'h0,        1'b1,
          '{32'hA5A5A5A5, STATUS_OK, 5'd1, 1'b0, 1'b1}},
        '{1'b0, 5'd0, FUNC_REMOVE,      32'h0,        1'b1,
          '{32'hA5A5A5A5, STATUS_OK, 5'd0, 1'b1, 1'b0}},
        '{1'b0, 5'd0, FUNC_APPEND,      32'h12345678, 1'b0, '0},
        '{1'b0, 5'd0, FUNC_REMOVE,      32'h0,        1'b0, '0},
        '{1'b1, 5'd31, FUNC_APPEND,     32'h0,        1'b0, '0},
        '{1'b0, 5'd0, FUNC_APPEND,      32'h0F0F0F0F, 1'b0, '0},
        '{1'b1, 5'd2,  FUNC_APPEND,     32'h0,        1'b0, '0},
        '{1'b0, 5'd0, FUNC_REMOVE,      32'h0,        1'b1,
          '{32'h0, STATUS_EMPTY, 5'd0, 1'b1, 1'b0}},
        '{1'b0, 5'd0, FUNC_APPEND,      32'h00000001, 1'b0, '0},
        '{1'b0, 5'd0, FUNC_APPEND,      32'h00000002, 1'b0, '0},
        '{1'b0, 5'd0, FUNC_APPEND,      32'h00000003, 1'b1,
          '{32'h0, STATUS_FULL, 5'd2, 1'b0, 1'b1}},
        '{1'b0, 5'd0, FUNC_REMOVE,      32'h0,        1'b0, '0},
        '{1'b0, 5'd0, FUNC_APPEND,      32'h80000004, 1'b0, '0},
        '{1'b0, 5'd0, FUNC_PEEK_NEWEST, 32'h0,        1'b0, '0},
        '{1'b0, 5'd0, FUNC_REMOVE,      32'h0,        1'b0, '0},
        '{1'b0, 5'd0, FUNC_REMOVE,      32'h0,        1'b0, '0},
        '{1'b0, 5'd0, FUNC_REMOVE,      32'h0,        1'b1,
          '{32'h0, STATUS_EMPTY, 5'd0, 1'b1, 1'b0}},
        '{1'b1, 5'd17, FUNC_APPEND,     32'h0,        1'b0, '0},
        '{1'b1, 5'd16, FUNC_APPEND,     32'h0,        1'b0, '0}
    };

    circular_fifo_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_data_in   (i_data_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_occupancy (o_occupancy),
        .o_is_empty  (o_is_empty),
        .o_is_full   (o_is_full),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_idx fifo_advance(t_idx idx);
        if (int'(idx) + 1 >= int'(q_cap)) begin
            return '0;
        end
        return idx + 1'b1;
    endfunction

    function automatic void fifo_set_capacity(t_cfg v);
        if (v == '0) begin
            q_cap = t_cnt'(1);
        end else if (int'(v) > DEPTH) begin
            q_cap = t_cnt'(DEPTH);
        end else begin
            q_cap = t_cnt'(v);
        end
        q_head  = '0;
        q_tail  = t_idx'(q_cap - 1'b1);
        q_count = '0;
    endfunction

    function automatic t_result fifo_step(t_func op, t_data d);
        t_result r;
        r = '0;
        r.status = STATUS_OK;
        if (op == FUNC_APPEND) begin
            if (q_count >= q_cap) begin
                r.status = STATUS_FULL;
            end else begin
                q_tail = fifo_advance(q_tail);
                q_slots[q_tail] = d;
                q_count = q_count + 1'b1;
            end
        end else if (q_count == '0) begin
            r.status = STATUS_EMPTY;
        end else if (op == FUNC_REMOVE) begin
            r.data  = q_slots[q_head];
            q_head  = fifo_advance(q_head);
            q_count = q_count - 1'b1;
        end else if (op == FUNC_PEEK_OLDEST) begin
            r.data = q_slots[q_head];
        end else begin
            r.data = q_slots[q_tail];
        end
        r.occ   = q_count;
        r.empty = (q_count == '0);
        r.full  = (q_count == q_cap);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= 30) begin
            $display("MISMATCH at cycle %0d, result %0d: %s", cycles, results_checked, msg);
        end
    endtask

    // Input acceptance feeds the predictor; output acceptance is checked against it.
    always @(posedge i_clk) begin
        t_result r;
        t_result got;
        if (i_rst_n) begin
            cycles++;
            if (i_in_valid && o_in_ready) begin
                r = fifo_step(i_func, i_data_in);
                if (cur_typed) begin
                    r = cur_want;
                end
                expected_results.push_back(r);
                words_in++;
            end
            if (o_out_valid && i_out_ready) begin
                got = '{o_data_out, o_status, o_occupancy, o_is_empty, o_is_full};
                rx_gap = rx_burst ? 0 : $urandom_range(0, 6);
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, data %h", o_data_out));
                end else begin
                    r = expected_results.pop_front();
                    if (got.data !== r.data) begin
                        report_mismatch($sformatf("data_out %h, expected %h", got.data, r.data));
                    end
                    if (got.status !== r.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, r.status));
                    end
                    if (got.occ !== r.occ) begin
                        report_mismatch($sformatf("occupancy %0d, expected %0d", got.occ, r.occ));
                    end
                    if (got.empty !== r.empty) begin
                        report_mismatch($sformatf("is_empty %b, expected %b",
                                                  got.empty, r.empty));
                    end
                    if (got.full !== r.full) begin
                        report_mismatch($sformatf("is_full %b, expected %b", got.full, r.full));
                    end
                    if (r.status == STATUS_FULL) begin
                        full_seen++;
                    end
                    if (r.status == STATUS_EMPTY) begin
                        empty_seen++;
                    end
                    results_checked++;
                end
            end
            if (cycles > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles with %0d results outstanding.",
                         cycles, expected_results.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            i_out_ready <= 1'b0;
            rx_gap--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_word(t_func op, t_data d, logic typed, t_result want);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cur_typed = typed;
        cur_want  = want;
        i_in_valid <= 1'b1;
        i_func     <= op;
        i_data_in  <= d;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_capacity(t_cfg v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        fifo_set_capacity(v);
        cap_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int    n_ops;
        int    pause_at;
        int    append_pct;
        t_func op;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_func      = FUNC_APPEND;
        i_data_in   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        cur_typed   = 1'b0;
        cur_want    = '0;
        tx_burst    = 1'b0;
        rx_burst    = 1'b0;
        rx_gap      = 0;
        errors      = 0;
        cycles      = 0;
        words_in    = 0;
        results_checked = 0;
        full_seen   = 0;
        empty_seen  = 0;
        cap_writes  = 0;
        for (int i = 0; i < DEPTH; i++) begin
            q_slots[i] = '0;
        end
        q_cap   = t_cnt'(DEPTH);
        q_head  = '0;
        q_tail  = t_idx'(DEPTH - 1);
        q_count = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < $size(directed_plan); i++) begin
            if (directed_plan[i].is_cfg) begin
                write_capacity(directed_plan[i].cfg);
            end else begin
                send_word(directed_plan[i].op, directed_plan[i].data,
                          directed_plan[i].typed, directed_plan[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            write_capacity((ph == 0) ? t_cfg'(DEPTH) : t_cfg'($urandom_range(0, 31)));
            tx_burst   = ($urandom_range(0, 3) == 0);
            rx_burst   = ($urandom_range(0, 3) == 0);
            append_pct = (ph == 0) ? 70 : 25 * $urandom_range(1, 3);
            n_ops      = $urandom_range(45, 65);
            pause_at   = $urandom_range(5, n_ops - 5);
            for (int k = 0; k < n_ops; k++) begin
                if (k == pause_at) begin
                    wait_idle();
                end
                if ($urandom_range(0, 99) < append_pct) begin
                    op = FUNC_APPEND;
                end else begin
                    op = t_func'($urandom_range(1, 3));
                end
                send_word(op, t_data'($urandom), 1'b0, '0);
            end
        end

        wait_idle();
        $display("Summary: %0d words sent and %0d results checked across %0d capacity writes.",
                 words_in, results_checked, cap_writes);
        $display("Summary: %0d appends refused as full, %0d reads refused as empty.",
                 full_seen, empty_seen);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+src
src/cfq_pkg.sv
src/cfq_ctrl.sv
src/cfq_dp.sv
src/circular_fifo_queue.sv
tb/sv/tb_top.sv
